>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL. All properties are clocked on clk and
// disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, expr)
`define ASSERT_IMPLIES(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> src/kvmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvmt_pkg
// Types and constants of the key-value map table.
// ----------------------------------------------------------------------------
package kvmt_pkg;

  localparam int CAPACITY    = 16;
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int KEY_PORT_W  = 32;
  localparam int VAL_PORT_W  = 32;
  localparam int CNT_PORT_W  = 5;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_CLEAR  = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    STAT_DONE = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } stat_t;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_APPLY = 1'b1
  } fsm_t;

  typedef struct packed {
    logic capture;
    logic ins;
    logic rem;
    logic upd;
  } cell_ctl_t;

endpackage

>>> src/kvmt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvmt_cell
// One slot of the table: holds a key and a value, compares against the
// incoming key and shifts with its neighbors on insert and remove.
// ----------------------------------------------------------------------------
module kvmt_cell (
  input  logic                               clk,
  input  kvmt_pkg::cell_ctl_t                ctl,
  input  logic [kvmt_pkg::KEY_WIDTH-1:0]     cmp_key,
  input  logic [kvmt_pkg::KEY_WIDTH-1:0]     op_key,
  input  logic [kvmt_pkg::VALUE_WIDTH-1:0]   op_value,
  input  logic                               self_valid,
  input  logic                               left_valid,
  input  logic                               left_gt,
  input  logic [kvmt_pkg::KEY_WIDTH-1:0]     left_key,
  input  logic [kvmt_pkg::VALUE_WIDTH-1:0]   left_value,
  input  logic [kvmt_pkg::KEY_WIDTH-1:0]     right_key,
  input  logic [kvmt_pkg::VALUE_WIDTH-1:0]   right_value,
  output logic [kvmt_pkg::KEY_WIDTH-1:0]     key_q,
  output logic [kvmt_pkg::VALUE_WIDTH-1:0]   value_q,
  output logic                               gt,
  output logic                               eq
);

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      eq <= self_valid && (key_q == cmp_key);
      gt <= self_valid && (key_q > cmp_key);
    end
    if (ctl.ins && !gt) begin
      if (left_gt) begin
        key_q   <= op_key;
        value_q <= op_value;
      end else if (left_valid) begin
        key_q   <= left_key;
        value_q <= left_value;
      end
    end
    if (ctl.rem && self_valid && !gt) begin
      key_q   <= right_key;
      value_q <= right_value;
    end
    if (ctl.upd && eq) begin
      value_q <= op_value;
    end
  end

endmodule

>>> src/key_value_map_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_value_map_table_unit
// Fixed-capacity key-value table built as a row of compare-and-shift slots.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries action, key and value; one beat
// is one operation: insert or update, remove, lookup or clear. Output channel
// (out_valid / out_stall) carries status, found, value_out and entry_count,
// one beat per input beat, in order.
// In each operation, at the accepting edge every slot compares its key with
// the incoming key; once the output register is free the slots update, shift
// away from the insertion point or close the gap of a removed entry, and the
// result is registered. No beat is accepted until that update is made.
// in_stall is high while an operation waits for or makes its update.
// A result waiting on a stalled receiver does not block the next accept; the
// update of that next operation holds until the output register frees.
// Reset empties the table (entry count zero) and drops any pending result;
// the slot contents are not cleared and are never read before written.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module key_value_map_table_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        action,
  input  logic [kvmt_pkg::KEY_PORT_W-1:0]   key,
  input  logic [kvmt_pkg::VAL_PORT_W-1:0]   value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        status,
  output logic                              found,
  output logic [kvmt_pkg::VAL_PORT_W-1:0]   value_out,
  output logic [kvmt_pkg::CNT_PORT_W-1:0]   entry_count
);

  localparam int N = kvmt_pkg::CAPACITY;

  kvmt_pkg::fsm_t                    state;
  kvmt_pkg::fsm_t                    state_next;
  kvmt_pkg::act_t                    op_action;
  logic [kvmt_pkg::KEY_WIDTH-1:0]    op_key;
  logic [kvmt_pkg::VALUE_WIDTH-1:0]  op_value;
  logic [kvmt_pkg::CNT_W-1:0]        count;
  logic [kvmt_pkg::CNT_W-1:0]        count_next;
  kvmt_pkg::cell_ctl_t               ctl;

  logic [kvmt_pkg::KEY_WIDTH-1:0]    cmp_key;
  logic [kvmt_pkg::KEY_WIDTH-1:0]    key_q   [N];
  logic [kvmt_pkg::VALUE_WIDTH-1:0]  value_q [N];
  logic [N-1:0]                      gt_vec;
  logic [N-1:0]                      eq_vec;
  logic [N-1:0]                      valid_vec;

  logic                              in_acc;
  logic                              can_finish;
  logic                              apply;
  logic                              hit;
  logic                              full;
  logic [kvmt_pkg::VALUE_WIDTH-1:0]  hit_value;
  kvmt_pkg::stat_t                   res_status;
  logic [kvmt_pkg::VALUE_WIDTH-1:0]  res_value;

  assign cmp_key    = key[kvmt_pkg::KEY_WIDTH-1:0];
  assign in_acc     = in_valid && !in_stall;
  assign can_finish = !out_valid || !out_stall;
  assign hit        = |eq_vec;
  assign full       = (count == kvmt_pkg::CNT_W'(N));

  always_comb begin
    state_next = state;
    case (state)
      kvmt_pkg::S_IDLE:  if (in_acc) state_next = kvmt_pkg::S_APPLY;
      kvmt_pkg::S_APPLY: if (can_finish) state_next = kvmt_pkg::S_IDLE;
      default:           state_next = kvmt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    apply    = 1'b0;
    case (state)
      kvmt_pkg::S_IDLE:  in_stall = 1'b0;
      kvmt_pkg::S_APPLY: apply = can_finish;
      default:           in_stall = 1'b1;
    endcase
  end

  always_comb begin
    ctl.capture = in_acc;
    ctl.ins     = apply && (op_action == kvmt_pkg::ACT_INSERT) && !hit && !full;
    ctl.rem     = apply && (op_action == kvmt_pkg::ACT_REMOVE) && hit;
    ctl.upd     = apply && (op_action == kvmt_pkg::ACT_INSERT) && hit;
  end

  always_comb begin
    hit_value = '0;
    for (int i = 0; i < N; i++) begin
      hit_value = hit_value | (value_q[i] & {kvmt_pkg::VALUE_WIDTH{eq_vec[i]}});
    end
  end

  always_comb begin
    count_next = count;
    res_status = kvmt_pkg::STAT_DONE;
    res_value  = '0;
    case (op_action)
      kvmt_pkg::ACT_INSERT: begin
        if (hit) begin
          res_value = op_value;
        end else if (full) begin
          res_status = kvmt_pkg::STAT_FULL;
        end else begin
          count_next = count + kvmt_pkg::CNT_W'(1);
        end
      end
      kvmt_pkg::ACT_REMOVE: begin
        if (hit) begin
          count_next = count - kvmt_pkg::CNT_W'(1);
        end else begin
          res_status = kvmt_pkg::STAT_MISS;
        end
      end
      kvmt_pkg::ACT_LOOKUP: begin
        if (hit) begin
          res_value = hit_value;
        end else begin
          res_status = kvmt_pkg::STAT_MISS;
        end
      end
      kvmt_pkg::ACT_CLEAR: count_next = '0;
      default:             count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kvmt_pkg::S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (apply) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_action <= kvmt_pkg::act_t'(action);
      op_key    <= cmp_key;
      op_value  <= value[kvmt_pkg::VALUE_WIDTH-1:0];
    end
    if (apply) begin
      status      <= res_status;
      found       <= hit && (op_action != kvmt_pkg::ACT_CLEAR);
      value_out   <= kvmt_pkg::VAL_PORT_W'(res_value);
      entry_count <= kvmt_pkg::CNT_PORT_W'(count_next);
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    assign valid_vec[i] = (kvmt_pkg::CNT_W'(i) < count);

    if (i == 0) begin : g_first
      kvmt_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .cmp_key     (cmp_key),
        .op_key      (op_key),
        .op_value    (op_value),
        .self_valid  (valid_vec[i]),
        .left_valid  (1'b1),
        .left_gt     (1'b1),
        .left_key    (op_key),
        .left_value  (op_value),
        .right_key   (key_q[(i + 1) % N]),
        .right_value (value_q[(i + 1) % N]),
        .key_q       (key_q[i]),
        .value_q     (value_q[i]),
        .gt          (gt_vec[i]),
        .eq          (eq_vec[i])
      );
    end else if (i == N - 1) begin : g_last
      kvmt_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .cmp_key     (cmp_key),
        .op_key      (op_key),
        .op_value    (op_value),
        .self_valid  (valid_vec[i]),
        .left_valid  (valid_vec[i - 1]),
        .left_gt     (gt_vec[i - 1]),
        .left_key    (key_q[i - 1]),
        .left_value  (value_q[i - 1]),
        .right_key   (key_q[i]),
        .right_value (value_q[i]),
        .key_q       (key_q[i]),
        .value_q     (value_q[i]),
        .gt          (gt_vec[i]),
        .eq          (eq_vec[i])
      );
    end else begin : g_mid
      kvmt_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .cmp_key     (cmp_key),
        .op_key      (op_key),
        .op_value    (op_value),
        .self_valid  (valid_vec[i]),
        .left_valid  (valid_vec[i - 1]),
        .left_gt     (gt_vec[i - 1]),
        .left_key    (key_q[i - 1]),
        .left_value  (value_q[i - 1]),
        .right_key   (key_q[i + 1]),
        .right_value (value_q[i + 1]),
        .key_q       (key_q[i]),
        .value_q     (value_q[i]),
        .gt          (gt_vec[i]),
        .eq          (eq_vec[i])
      );
    end
  end

  `ASSERT_ALWAYS(a_count_in_range, count <= kvmt_pkg::CNT_W'(N))
  `ASSERT_IMPLIES(a_keys_unique, state == kvmt_pkg::S_APPLY, $onehot0(eq_vec))
  `ASSERT_NEXT(a_accept_to_apply, in_acc, state == kvmt_pkg::S_APPLY)
  `ASSERT_IMPLIES(a_miss_not_found, out_valid && status != kvmt_pkg::STAT_DONE, !found)

endmodule

>>> dv/key_value_map_table_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_value_map_table_unit_test
// Self-checking bench for the key-value map table. A tracker keeps its own
// copy of the table contents and queues the expected result of every beat
// accepted at the input. Results are matched in order, field by field. A
// directed opening covers field extremes, update, miss, full and clear. A
// random run over a small key pool follows, so hits and a full table are
// common. It runs in three phases; sender and receiver idle at random in the first two.
// ----------------------------------------------------------------------------
module key_value_map_table_unit_test;

  localparam int KEY_POOL   = 24;
  localparam int QUIET_MAX  = 4000;
  localparam int PHASE_LEN  = 610;

  typedef struct {
    kvmt_pkg::stat_t                  st;
    logic                             fd;
    logic [kvmt_pkg::VAL_PORT_W-1:0]  vo;
    logic [kvmt_pkg::CNT_PORT_W-1:0]  cnt;
  } kv_result_t;

  class kv_table_tracker;
    logic [kvmt_pkg::KEY_PORT_W-1:0] keys [kvmt_pkg::CAPACITY];
    logic [kvmt_pkg::VAL_PORT_W-1:0] vals [kvmt_pkg::CAPACITY];
    int                              used;
    kv_result_t                      pending[$];
    int                              errors;

    function void note_request(kvmt_pkg::act_t act, logic [kvmt_pkg::KEY_PORT_W-1:0] k,
                               logic [kvmt_pkg::VAL_PORT_W-1:0] v);
      kv_result_t r;
      int         slot;
      slot = -1;
      for (int i = 0; i < used; i++)
        if (slot < 0 && keys[i] == k) slot = i;
      r.st = kvmt_pkg::STAT_DONE;
      r.fd = 1'b0;
      r.vo = '0;
      case (act)
        kvmt_pkg::ACT_INSERT: begin
          if (slot >= 0) begin
            vals[slot] = v;
            r.fd = 1'b1;
            r.vo = v;
          end else if (used == kvmt_pkg::CAPACITY) begin
            r.st = kvmt_pkg::STAT_FULL;
          end else begin
            keys[used] = k;
            vals[used] = v;
            used++;
          end
        end
        kvmt_pkg::ACT_REMOVE: begin
          if (slot >= 0) begin
            r.fd = 1'b1;
            for (int i = slot; i + 1 < used; i++) begin
              keys[i] = keys[i + 1];
              vals[i] = vals[i + 1];
            end
            used--;
          end else begin
            r.st = kvmt_pkg::STAT_MISS;
          end
        end
        kvmt_pkg::ACT_LOOKUP: begin
          if (slot >= 0) begin
            r.fd = 1'b1;
            r.vo = vals[slot];
          end else begin
            r.st = kvmt_pkg::STAT_MISS;
          end
        end
        default: used = 0;
      endcase
      r.cnt = kvmt_pkg::CNT_PORT_W'(used);
      pending.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [1:0] st, logic fd,
                               logic [kvmt_pkg::VAL_PORT_W-1:0] vo,
                               logic [kvmt_pkg::CNT_PORT_W-1:0] cnt);
      kv_result_t r;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result expected none actual status %0h count %0h",
                 $time, st, cnt);
        return;
      end
      r = pending.pop_front();
      compare_field("status", 32'(r.st), 32'(st));
      compare_field("found", 32'(r.fd), 32'(fd));
      compare_field("value_out", r.vo, vo);
      compare_field("entry_count", 32'(r.cnt), 32'(cnt));
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [1:0]                      action = '0;
  logic [kvmt_pkg::KEY_PORT_W-1:0] key = '0;
  logic [kvmt_pkg::VAL_PORT_W-1:0] value = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [1:0]                      status;
  logic                            found;
  logic [kvmt_pkg::VAL_PORT_W-1:0] value_out;
  logic [kvmt_pkg::CNT_PORT_W-1:0] entry_count;

  kv_table_tracker                 book;
  int                              tx_idle_pct = 8;
  int                              rx_idle_pct = 82;
  int                              quiet_cycles = 0;
  logic [kvmt_pkg::KEY_PORT_W-1:0] key_pool [KEY_POOL];

  key_value_map_table_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .key         (key),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .found       (found),
    .value_out   (value_out),
    .entry_count (entry_count)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      book.check_result(status, found, value_out, entry_count);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_MAX) begin
        $display("FAIL key_value_map_table_unit");
        $finish;
      end
    end
  end

  task automatic send_beat(kvmt_pkg::act_t a, logic [kvmt_pkg::KEY_PORT_W-1:0] k,
                           logic [kvmt_pkg::VAL_PORT_W-1:0] v);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action   <= a;
    key      <= k;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.note_request(a, k, v);
    @(negedge clk);
  endtask

  task automatic run_random(int n);
    int                              pick;
    kvmt_pkg::act_t                  a;
    logic [kvmt_pkg::KEY_PORT_W-1:0] k;
    logic [kvmt_pkg::VAL_PORT_W-1:0] v;
    for (int i = 0; i < KEY_POOL; i++) key_pool[i] = $urandom;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50)      a = kvmt_pkg::ACT_INSERT;
      else if (pick < 66) a = kvmt_pkg::ACT_REMOVE;
      else if (pick < 98) a = kvmt_pkg::ACT_LOOKUP;
      else                a = kvmt_pkg::ACT_CLEAR;
      k = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, KEY_POOL - 1)];
      case ($urandom_range(0, 15))
        0:       v = '0;
        1:       v = '1;
        default: v = $urandom;
      endcase
      send_beat(a, k, v);
    end
  endtask

  initial begin
    book = new();
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_beat(kvmt_pkg::ACT_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_beat(kvmt_pkg::ACT_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_beat(kvmt_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 32'h1234_5678);
    send_beat(kvmt_pkg::ACT_INSERT, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
    send_beat(kvmt_pkg::ACT_REMOVE, 32'h0000_0000, 32'h0000_0000);
    send_beat(kvmt_pkg::ACT_REMOVE, 32'h0000_0000, 32'hFFFF_FFFF);
    send_beat(kvmt_pkg::ACT_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    for (int i = 1; i < kvmt_pkg::CAPACITY; i++)
      send_beat(kvmt_pkg::ACT_INSERT, (32'(i) << 27) | 32'(i), ~(32'(i) << 20));
    send_beat(kvmt_pkg::ACT_INSERT, 32'h5A5A_5A5A, 32'hC3C3_C3C3);
    send_beat(kvmt_pkg::ACT_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    run_random(PHASE_LEN);
    tx_idle_pct = 82;
    rx_idle_pct = 8;
    run_random(PHASE_LEN);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(PHASE_LEN);
    in_valid <= 1'b0;

    while (book.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (book.errors == 0 && book.pending.size() == 0) begin
      $display("PASS key_value_map_table_unit");
    end else begin
      $display("FAIL key_value_map_table_unit");
    end
    $finish;
  end

endmodule

>>> key_value_map_table_unit.f
+incdir+src
src/kvmt_pkg.sv
src/kvmt_cell.sv
src/key_value_map_table_unit.sv
dv/key_value_map_table_unit_test.sv
